>>> hw/rtl/smac_pkg.sv
// Shared types and constants of the shadow memory access checker.
`default_nettype none

package smac_pkg;

    localparam int SHADOW_ENTRIES = 4096;
    localparam int MAX_LENGTH     = 4096;
    localparam int SLOT_W         = $clog2(SHADOW_ENTRIES);
    localparam int ADDR_W         = 32;
    localparam int LEN_W          = 13;
    localparam int IN_SLOT_W      = 12;
    localparam int SHADOW_W       = 8;
    localparam int GRANULE_SHIFT  = 3;
    localparam int CFG_INDEX_W    = 2;

    typedef enum logic [1:0] {
        ST_UNCHECKED = 2'd0,
        ST_CLEAN     = 2'd1,
        ST_POISONED  = 2'd2,
        ST_WRAPS     = 2'd3
    } t_status;

    typedef enum logic {
        OP_CHECK     = 1'b0,
        OP_SHADOW_WR = 1'b1
    } t_opcode;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ENABLED      = 2'd0,
        CFG_REGION_START = 2'd1,
        CFG_REGION_LAST  = 2'd2,
        CFG_CHECK_FLOOR  = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic                       opcode;
        logic [ADDR_W-1:0]          address;
        logic [LEN_W-1:0]           length;
        logic                       is_store;
        logic [IN_SLOT_W-1:0]       shadow_slot;
        logic signed [SHADOW_W-1:0] shadow_byte;
    } t_cmd;

    typedef struct packed {
        t_status status;
        logic    store_echo;
    } t_result;

    typedef struct packed {
        logic              enabled;
        logic [ADDR_W-1:0] region_start;
        logic [ADDR_W-1:0] region_last;
        logic [ADDR_W-1:0] check_floor;
    } t_cfg;

endpackage

`default_nettype wire

>>> hw/rtl/smac_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module smac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/smac_ctrl.sv
// Sequencer: clearing pass, range pre-checks and shadow scan over the shadow RAM ports.
`default_nettype none

module smac_ctrl (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire smac_pkg::t_cfg                        i_cfg,
    input  wire logic                                  i_start,
    input  wire smac_pkg::t_cmd                        i_cmd,
    output logic                                       o_busy,
    output logic                                       o_result_valid,
    output smac_pkg::t_result                          o_result,
    output logic                                       o_ram_we,
    output logic [smac_pkg::SLOT_W-1:0]                o_ram_waddr,
    output logic [smac_pkg::SHADOW_W-1:0]              o_ram_wdata,
    output logic                                       o_ram_re,
    output logic [smac_pkg::SLOT_W-1:0]                o_ram_raddr,
    input  wire logic [smac_pkg::SHADOW_W-1:0]         i_ram_rdata
);

    localparam int RELS_W = smac_pkg::ADDR_W - smac_pkg::GRANULE_SHIFT;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PRE,
        S_SPAN,
        S_SCAN
    } t_state;

    t_state                              r_state, n_state;
    smac_pkg::t_cmd                      r_cmd;
    logic [smac_pkg::SLOT_W-1:0]         r_slot, n_slot;
    logic [smac_pkg::SLOT_W-1:0]         r_last_slot, n_last_slot;
    logic [smac_pkg::ADDR_W-1:0]         r_last, n_last;
    logic [smac_pkg::ADDR_W-1:0]         r_rel_first, n_rel_first;
    logic [smac_pkg::GRANULE_SHIFT-1:0]  r_off, n_off;
    logic                                r_pend, n_pend;
    logic                                r_pend_last, n_pend_last;
    logic                                r_issued_last, n_issued_last;
    logic                                r_valid, n_valid;
    smac_pkg::t_status                   r_status, n_status;

    logic                                accept;
    logic                                wr_slot_ok;
    logic [smac_pkg::ADDR_W:0]           end_sum;
    logic [smac_pkg::ADDR_W-1:0]         rel_last;
    logic                                done;
    logic signed [smac_pkg::SHADOW_W-1:0] shadow_val;
    logic signed [smac_pkg::SHADOW_W-1:0] off_val;

    assign accept     = i_start && (r_state == S_IDLE);
    assign wr_slot_ok = 32'(i_cmd.shadow_slot) < 32'(smac_pkg::SHADOW_ENTRIES);
    assign end_sum    = {1'b0, r_cmd.address} + (smac_pkg::ADDR_W + 1)'(r_cmd.length);
    assign rel_last   = r_last - i_cfg.region_start;
    assign shadow_val = $signed(i_ram_rdata);
    assign off_val    = $signed({(smac_pkg::SHADOW_W - smac_pkg::GRANULE_SHIFT)'(0), r_off});

    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = smac_pkg::SLOT_W'(i_cmd.shadow_slot);
        o_ram_wdata = i_cmd.shadow_byte;
        if (r_state == S_CLEAR) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = r_slot;
            o_ram_wdata = '0;
        end else if (accept && (i_cmd.opcode == smac_pkg::OP_SHADOW_WR) && wr_slot_ok) begin
            o_ram_we = 1'b1;
        end
    end

    assign o_ram_re    = (r_state == S_SCAN) && !r_issued_last;
    assign o_ram_raddr = r_slot;

    always_comb begin
        n_state       = r_state;
        n_slot        = r_slot;
        n_last_slot   = r_last_slot;
        n_last        = r_last;
        n_rel_first   = r_rel_first;
        n_off         = r_off;
        n_pend        = 1'b0;
        n_pend_last   = r_pend_last;
        n_issued_last = r_issued_last;
        n_valid       = 1'b0;
        n_status      = r_status;
        done          = 1'b0;
        case (r_state)
            S_CLEAR: begin
                n_slot = r_slot + 1'b1;
                if (r_slot == smac_pkg::SLOT_W'(smac_pkg::SHADOW_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && (i_cmd.opcode == smac_pkg::OP_CHECK)) begin
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                n_last      = end_sum[smac_pkg::ADDR_W-1:0] - 1'b1;
                n_rel_first = r_cmd.address - i_cfg.region_start;
                n_state     = S_IDLE;
                n_valid     = 1'b1;
                if (!i_cfg.enabled || (r_cmd.address < i_cfg.region_start) ||
                    (r_cmd.address > i_cfg.region_last) || (r_cmd.length == '0)) begin
                    n_status = smac_pkg::ST_UNCHECKED;
                end else if (end_sum[smac_pkg::ADDR_W] &&
                             (end_sum[smac_pkg::ADDR_W-1:0] != '0)) begin
                    n_status = smac_pkg::ST_WRAPS;
                end else if ((r_cmd.address < i_cfg.check_floor) ||
                             (32'(r_cmd.length) > 32'(smac_pkg::MAX_LENGTH))) begin
                    n_status = smac_pkg::ST_UNCHECKED;
                end else begin
                    n_state = S_SPAN;
                    n_valid = 1'b0;
                end
            end
            S_SPAN: begin
                n_slot        = smac_pkg::SLOT_W'(r_rel_first[smac_pkg::ADDR_W-1:
                                                  smac_pkg::GRANULE_SHIFT]);
                n_last_slot   = smac_pkg::SLOT_W'(rel_last[smac_pkg::ADDR_W-1:
                                                  smac_pkg::GRANULE_SHIFT]);
                n_off         = rel_last[smac_pkg::GRANULE_SHIFT-1:0];
                n_issued_last = 1'b0;
                if ((r_rel_first[smac_pkg::ADDR_W-1:smac_pkg::GRANULE_SHIFT] >=
                     RELS_W'(smac_pkg::SHADOW_ENTRIES)) ||
                    (rel_last[smac_pkg::ADDR_W-1:smac_pkg::GRANULE_SHIFT] >=
                     RELS_W'(smac_pkg::SHADOW_ENTRIES))) begin
                    n_status = smac_pkg::ST_UNCHECKED;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_pend) begin
                    if (shadow_val != '0) begin
                        done     = 1'b1;
                        n_status = (!r_pend_last || (off_val >= shadow_val)) ?
                                   smac_pkg::ST_POISONED : smac_pkg::ST_CLEAN;
                    end else if (r_pend_last) begin
                        done     = 1'b1;
                        n_status = smac_pkg::ST_CLEAN;
                    end
                end
                if (done) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (!r_issued_last) begin
                    n_pend        = 1'b1;
                    n_pend_last   = (r_slot == r_last_slot);
                    n_issued_last = (r_slot == r_last_slot);
                    n_slot        = r_slot + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_slot  <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
        if (accept) begin
            r_cmd <= i_cmd;
        end
        r_last_slot   <= n_last_slot;
        r_last        <= n_last;
        r_rel_first   <= n_rel_first;
        r_off         <= n_off;
        r_pend_last   <= n_pend_last;
        r_issued_last <= n_issued_last;
        r_status      <= n_status;
    end

    assign o_busy              = (r_state != S_IDLE);
    assign o_result_valid      = r_valid;
    assign o_result.status     = r_status;
    assign o_result.store_echo = r_cmd.is_store;

endmodule

`default_nettype wire

>>> hw/rtl/shadow_memory_access_checker.sv
// Shadow memory access checker: config registers, sequencer and shadow byte RAM.
// Check word: settled by the address tests in S_PRE, or by the span test in S_SPAN
// when its span leaves the store, else by a scan of its shadow bytes (one RAM read a
// cycle, early stop). A shadow write word gives no result. The result strobe is high
// for one cycle only; the receiver cannot stall it.
// After reset all 4096 shadow RAM entries are zeroed with busy high.
`default_nettype none

module shadow_memory_access_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [smac_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [smac_pkg::ADDR_W-1:0]         i_cfg_wdata,
    input  wire logic                                i_start,
    input  wire smac_pkg::t_cmd                      i_cmd,
    output logic                                     o_busy,
    output logic                                     o_result_valid,
    output smac_pkg::t_result                        o_result
);

    smac_pkg::t_cfg                   r_cfg;
    logic                             ram_we;
    logic [smac_pkg::SLOT_W-1:0]      ram_waddr;
    logic [smac_pkg::SHADOW_W-1:0]    ram_wdata;
    logic                             ram_re;
    logic [smac_pkg::SLOT_W-1:0]      ram_raddr;
    logic [smac_pkg::SHADOW_W-1:0]    ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (smac_pkg::t_cfg_index'(i_cfg_index))
                smac_pkg::CFG_ENABLED:      r_cfg.enabled      <= i_cfg_wdata[0];
                smac_pkg::CFG_REGION_START: r_cfg.region_start <= i_cfg_wdata;
                smac_pkg::CFG_REGION_LAST:  r_cfg.region_last  <= i_cfg_wdata;
                smac_pkg::CFG_CHECK_FLOOR:  r_cfg.check_floor  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    smac_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_start        (i_start),
        .i_cmd          (i_cmd),
        .o_busy         (o_busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_re       (ram_re),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata)
    );

    smac_ram #(
        .WIDTH (smac_pkg::SHADOW_W),
        .DEPTH (smac_pkg::SHADOW_ENTRIES)
    ) u_shadow_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire
